@@ src/qbd_pkg.sv @@
// Package with shared types, constants and a conversion function of the block dequantizer.
`timescale 1ns / 1ps
package qbd_pkg;

  typedef enum logic [1:0] {
    MODE_HALF = 2'd0,
    MODE_Q4   = 2'd1,
    MODE_Q8   = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam logic OP_SCALE = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;
  localparam logic [31:0] MillionBits = 32'h4974_2400;
  localparam logic [30:0] InfMag      = 31'h7F80_0000;

  typedef struct packed {
    logic        op;
    logic [15:0] half_word;
    logic [7:0]  quant_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [4:0]  element_index;
    logic        bad_value;
    logic        last;
  } out_item_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] fr;
    logic [3:0] lz;
    logic [9:0] nf;
    logic [7:0] e;
    ex = h[14:10];
    fr = h[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) lz = 4'(9 - i);
    end
    nf = 10'(fr << (lz + 4'd1));
    e = 8'(8'd112 - {4'd0, lz});
    if (ex == 5'd0) begin
      if (fr == 10'd0) begin
        half_to_single = {h[15], 31'd0};
      end else begin
        half_to_single = {h[15], e, nf, 13'd0};
      end
    end else if (ex == 5'h1f) begin
      if (fr == 10'd0) begin
        half_to_single = {h[15], 8'hff, 23'd0};
      end else begin
        half_to_single = CanonNan;
      end
    end else begin
      half_to_single = {h[15], 8'({3'd0, ex} + 8'd112), fr, 13'd0};
    end
  endfunction

endpackage

@@ src/quant_block_dequantizer.sv @@
// Top level of the block dequantizer: input register, datapath and four-slot result queue.
`timescale 1ns / 1ps
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid_i/stall | qbd_pkg::in_item_t
// out     | output    | out_valid_o/stall| qbd_pkg::out_item_t
// cfg     | input     | cfg_valid_i/ready| format_mode, 2 bits
// An input transaction is registered, computed in one pass and lands in a
// result queue at the next edge, from which its results are offered in order.
// A data transaction in four-bit mode yields two results; the output, which takes
// one result per cycle when not stalled, then holds the input back. Other transactions
// sustain one per cycle unless the output stalls. Reset clears mode, scale and position.
// The input stalls only when the result queue lacks room for what may arrive.
module quant_block_dequantizer #(
  parameter int BLOCK_ELEMENTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qbd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qbd_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  localparam int PosW = $clog2(BLOCK_ELEMENTS);
  localparam int HalfW = PosW - 1;

  qbd_pkg::mode_e mode_q;
  logic [31:0]    scale_q;
  logic [PosW-1:0] pos_q;

  logic              iv_q;
  qbd_pkg::in_item_t ir_q;

  qbd_pkg::out_item_t fifo_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;

  logic in_acc, out_acc;
  logic [31:0] half_val, v0, v1;
  logic        b0, b1;
  logic [7:0]  q0, q1;
  qbd_pkg::out_item_t r0, r1;
  logic [1:0]  nres;
  logic [PosW-1:0] slot;

  assign cfg_ready_o = 1'b1;
  // Room for what is in flight plus a worst-case new pair.
  assign in_stall_o  = (cnt_q + 3'(nres)) > 3'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = fifo_q[rd_q];
  assign out_acc     = out_valid_o && !out_stall_i;

  assign half_val = qbd_pkg::half_to_single(ir_q.half_word);
  assign slot = (mode_q == qbd_pkg::MODE_Q4) ? {1'b0, pos_q[HalfW-1:0]} : pos_q;

  always_comb begin
    q0 = ir_q.quant_byte;
    q1 = 8'({4'd0, ir_q.quant_byte[7:4]} - 8'd8);
    if (mode_q == qbd_pkg::MODE_Q4) q0 = 8'({4'd0, ir_q.quant_byte[3:0]} - 8'd8);
  end

  qbd_mul u_mul0 (.scale_i(scale_q), .q_i(q0), .value_o(v0), .bad_o(b0));
  qbd_mul u_mul1 (.scale_i(scale_q), .q_i(q1), .value_o(v1), .bad_o(b1));

  always_comb begin
    r0 = '0;
    r1 = '0;
    nres = 2'd0;
    if (iv_q && ir_q.op == qbd_pkg::OP_DATA) begin
      unique case (mode_q)
        qbd_pkg::MODE_HALF: begin
          r0.value_bits = half_val;
          r0.bad_value = (half_val[30:0] > qbd_pkg::MillionBits[30:0]);
          r0.last = 1'b1;
          nres = 2'd1;
        end
        qbd_pkg::MODE_Q4: begin
          r0 = '{value_bits: v0, element_index: 5'(slot), bad_value: b0, last: 1'b0};
          r1 = '{value_bits: v1, element_index: 5'(slot) + 5'(BLOCK_ELEMENTS / 2),
                 bad_value: b1, last: 1'b1};
          nres = 2'd2;
        end
        qbd_pkg::MODE_Q8: begin
          r0 = '{value_bits: v0, element_index: 5'(slot), bad_value: b0, last: 1'b1};
          nres = 2'd1;
        end
        default: nres = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= qbd_pkg::MODE_HALF;
      scale_q <= '0;
      pos_q   <= '0;
      iv_q    <= 1'b0;
      rd_q    <= '0;
      wr_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= qbd_pkg::mode_e'(cfg_data_i);
      iv_q <= in_acc;
      if (iv_q) begin
        if (ir_q.op == qbd_pkg::OP_SCALE) begin
          scale_q <= half_val;
          pos_q   <= '0;
        end else if (mode_q == qbd_pkg::MODE_Q4) begin
          pos_q <= {1'b0, HalfW'(slot[HalfW-1:0] + HalfW'(1))};
        end else if (mode_q == qbd_pkg::MODE_Q8) begin
          pos_q <= slot + PosW'(1);
        end
      end
      if (nres != 2'd0) begin
        wr_q <= wr_q + 2'(nres);
      end
      if (out_acc) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(nres) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) ir_q <= in_data_i;
    if (nres != 2'd0) fifo_q[wr_q] <= r0;
    if (nres == 2'd2) fifo_q[wr_q + 2'd1] <= r1;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.value_bits[30:23] == 8'hff && out_data_o.value_bits[22:0] != 0
    |-> out_data_o.value_bits == qbd_pkg::CanonNan && out_data_o.bad_value)
    else $error("noncanonical NaN");
  a_q4_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == qbd_pkg::MODE_Q4 && $stable(mode_q) && $past(mode_q) == qbd_pkg::MODE_Q4
    && $past(iv_q) |-> !pos_q[PosW-1])
    else $error("four-bit position out of range");
endmodule

@@ src/qbd_mul.sv @@
// Product of a single-precision scale and a small signed integer, truncated to single precision, with flagging.
`timescale 1ns / 1ps
module qbd_mul (
  input  logic [31:0] scale_i,
  input  logic [7:0]  q_i,
  output logic [31:0] value_o,
  output logic        bad_o
);
  localparam logic [31:0] CanonNanW = qbd_pkg::CanonNan;

  logic        qs, sgn;
  logic [7:0]  qm;
  logic [7:0]  se;
  logic [23:0] sm;
  logic [31:0] prod;
  logic [3:0]  lz;
  logic [31:0] norm;
  logic [9:0]  ebase;
  logic [9:0]  eres;
  logic [9:0]  shr;
  logic [31:0] den;
  logic [31:0] raw;

  always_comb begin
    qs = q_i[7];
    qm = qs ? 8'(-q_i) : q_i;
    sgn = scale_i[31] ^ qs;
    se = scale_i[30:23];
    sm = (se == 8'd0) ? {1'b0, scale_i[22:0]} : {1'b1, scale_i[22:0]};
    prod = 32'(sm) * 32'(qm);
    lz = 4'd8;
    for (int i = 0; i < 9; i++) begin
      if (prod[23 + i]) lz = 4'(8 - i);
    end
    ebase = (se == 8'd0) ? 10'd1 : {2'd0, se};
    raw = {sgn, 31'd0};
    norm = 32'd0;
    eres = 10'd0;
    shr = 10'd0;
    den = 32'd0;
    if (se == 8'hff) begin
      if (scale_i[22:0] != 23'd0 || qm == 8'd0) begin
        raw = CanonNanW;
      end else begin
        raw = {sgn, 8'hff, 23'd0};
      end
    end else if (prod != 32'd0) begin
      if (prod[31:23] == 9'd0) begin
        // Product of a subnormal scale that stays below the normal range.
        raw = {sgn, 8'd0, prod[22:0]};
      end else begin
        norm = prod << lz;
        eres = ebase + 10'd8 - {6'd0, lz};
        if (eres[9] || eres == 10'd0) begin
          shr = 10'd1 - eres;
          den = norm >> shr;
          raw = {sgn, 8'd0, den[31:9]};
        end else begin
          raw = {sgn, eres[7:0], norm[30:8]};
        end
      end
    end
    value_o = raw;
    bad_o = 1'b0;
    if (raw[30:0] > qbd_pkg::InfMag) begin
      value_o = qbd_pkg::CanonNan;
      bad_o = 1'b1;
    end else if (raw[30:0] > qbd_pkg::MillionBits[30:0]) begin
      bad_o = 1'b1;
    end
  end
endmodule

@@ tb/sv/quant_block_dequantizer_chk.sv @@
// Checker that predicts and compares the results of the block dequantizer.
`timescale 1ns / 1ps
module quant_block_dequantizer_chk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  qbd_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  qbd_pkg::out_item_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  qbd_pkg::mode_e     mode_q;
  logic [31:0]        scale_q;
  logic [4:0]         pos_q;
  qbd_pkg::out_item_t expected_q[$];

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] res;
    logic [10:0] fr;
    int          ex;
    ex = 113;
    fr = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (fr == 11'd0) begin
        res = {h[15], 31'd0};
      end else begin
        while (!fr[10]) begin
          fr = fr << 1;
          ex--;
        end
        res = {h[15], 8'(ex), fr[9:0], 13'd0};
      end
    end else if (h[14:10] == 5'h1f) begin
      res = (h[9:0] == 10'd0) ? {h[15], 8'hff, 23'd0} : qbd_pkg::CanonNan;
    end else begin
      res = {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
    end
    return res;
  endfunction

  function automatic logic [31:0] scaled_value(input logic [31:0] s, input int q);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] prod;
    int          msb;
    sgn = s[31] ^ (q < 0);
    mag = (q < 0) ? -q : q;
    if (s[30:23] == 8'hff) begin
      if (s[22:0] != 23'd0 || mag == 0) return qbd_pkg::CanonNan;
      return {sgn, 8'hff, 23'd0};
    end
    if (s[30:0] == 31'd0 || mag == 0) return {sgn, 31'd0};
    prod = {8'd0, 1'b1, s[22:0]} * mag;
    msb = 23;
    for (int i = 23; i < 32; i++) if (prod[i]) msb = i;
    prod = prod >> (msb - 23);
    return {sgn, 8'(s[30:23] + msb - 23), prod[22:0]};
  endfunction

  function automatic qbd_pkg::out_item_t make_result(input logic [31:0] v,
                                                     input logic [4:0] idx,
                                                     input logic lst);
    qbd_pkg::out_item_t r;
    r.value_bits = v;
    r.bad_value = 1'b0;
    if (v[30:0] > qbd_pkg::InfMag) begin
      r.value_bits = qbd_pkg::CanonNan;
      r.bad_value = 1'b1;
    end else if (v[30:0] > qbd_pkg::MillionBits[30:0]) begin
      r.bad_value = 1'b1;
    end
    r.element_index = idx;
    r.last = lst;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    qbd_pkg::out_item_t got;
    qbd_pkg::out_item_t exp_item;
    logic [4:0] slot;
    if (!rst_ni) begin
      mode_q <= qbd_pkg::MODE_HALF;
      scale_q <= 32'd0;
      pos_q <= 5'd0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) mode_q <= qbd_pkg::mode_e'(cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op == qbd_pkg::OP_SCALE) begin
          scale_q <= widen_half(in_data_i.half_word);
          pos_q <= 5'd0;
        end else begin
          case (mode_q)
            qbd_pkg::MODE_HALF: begin
              expected_q.push_back(make_result(widen_half(in_data_i.half_word), 5'd0, 1'b1));
            end
            qbd_pkg::MODE_Q4: begin
              slot = {1'b0, pos_q[3:0]};
              expected_q.push_back(make_result(
                scaled_value(scale_q, int'(in_data_i.quant_byte[3:0]) - 8), slot, 1'b0));
              expected_q.push_back(make_result(
                scaled_value(scale_q, int'(in_data_i.quant_byte[7:4]) - 8), slot + 5'd16, 1'b1));
              pos_q <= {1'b0, 4'(slot + 5'd1)};
            end
            qbd_pkg::MODE_Q8: begin
              expected_q.push_back(make_result(
                scaled_value(scale_q, int'($signed(in_data_i.quant_byte))), pos_q, 1'b1));
              pos_q <= pos_q + 5'd1;
            end
            default: begin
            end
          endcase
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (got !== exp_item) begin
            if (got.value_bits !== exp_item.value_bits)
              $error("value_bits expected %h actual %h", exp_item.value_bits, got.value_bits);
            if (got.element_index !== exp_item.element_index)
              $error("element_index expected %0d actual %0d", exp_item.element_index,
                     got.element_index);
            if (got.bad_value !== exp_item.bad_value)
              $error("bad_value expected %0d actual %0d", exp_item.bad_value, got.bad_value);
            if (got.last !== exp_item.last)
              $error("last expected %0d actual %0d", exp_item.last, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/quant_block_dequantizer_tb.sv @@
// Testbench top that drives the block dequantizer and reports the verdict.
`timescale 1ns / 1ps
module quant_block_dequantizer_tb;
  localparam int CycleLimit = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  qbd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  qbd_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_data;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 burst_left;
  logic               hold_req;

  quant_block_dequantizer DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  quant_block_dequantizer_chk u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver stalls in random patterns, with one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        case ((cycles / 200) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic send(input logic op, input logic [15:0] hw, input logic [7:0] qb);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{op: op, half_word: hw, quant_byte: qb};
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic set_mode(input qbd_pkg::mode_e m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 5'h1f, 10'(($urandom_range(0, 1)) ?
                 $urandom : 0)};
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 5'd0, 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    qbd_pkg::mode_e modes[6];
    int n;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 2'd0;
    hold_req = 1'b0;
    burst_left = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(qbd_pkg::OP_DATA, 16'h0000, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h8000, 8'hff);
    send(qbd_pkg::OP_DATA, 16'h0001, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h83ff, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h7bff, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h7c00, 8'h00);
    send(qbd_pkg::OP_DATA, 16'hfc00, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h7e01, 8'h00);
    send(qbd_pkg::OP_SCALE, 16'h3c00, 8'h00);
    set_mode(qbd_pkg::MODE_Q4);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'hff);
    send(qbd_pkg::OP_SCALE, 16'h3c00, 8'h00);
    send(qbd_pkg::OP_DATA, 16'hffff, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'hff);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'h0f);
    send(qbd_pkg::OP_SCALE, 16'h7c00, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'h88);
    send(qbd_pkg::OP_SCALE, 16'h7e00, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'h12);
    set_mode(qbd_pkg::MODE_Q8);
    send(qbd_pkg::OP_SCALE, 16'h7bff, 8'h00);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'h80);
    send(qbd_pkg::OP_DATA, 16'h0000, 8'h7f);
    set_mode(qbd_pkg::MODE_NONE);
    send(qbd_pkg::OP_DATA, 16'h3c00, 8'h55);
    send(qbd_pkg::OP_SCALE, 16'h4000, 8'h00);

    modes = '{qbd_pkg::MODE_Q4, qbd_pkg::MODE_Q8, qbd_pkg::MODE_HALF, qbd_pkg::MODE_Q4,
              qbd_pkg::MODE_NONE, qbd_pkg::MODE_Q8};
    hold_req = 1'b1;
    foreach (modes[p]) begin
      set_mode(modes[p]);
      n = 0;
      while (n < 150) begin
        if ($urandom_range(0, 9) == 0) begin
          send($urandom_range(0, 1) ? qbd_pkg::OP_DATA : qbd_pkg::OP_SCALE, 16'($urandom),
               8'($urandom));
          n++;
        end else begin
          send(qbd_pkg::OP_SCALE, rand_half(), 8'($urandom));
          n++;
          repeat ($urandom_range(0, 34)) begin
            send(qbd_pkg::OP_DATA, rand_half(), 8'($urandom));
            n++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/qbd_pkg.sv
src/qbd_mul.sv
src/quant_block_dequantizer.sv
tb/sv/quant_block_dequantizer_chk.sv
tb/sv/quant_block_dequantizer_tb.sv
